>>> sv/bcr_pkg.sv
`timescale 1ns / 1ps
// bcr_pkg: request and result types for the GF(2) boundary column reducer.
// No dependencies.
package bcr_pkg;

  typedef struct packed {
    logic [63:0] column_word;
    logic        end_of_column;
    logic        end_of_matrix;
  } bcr_req_t;

  typedef struct packed {
    logic [5:0] column_number;
    logic [7:0] pivot_row;
    logic       has_pivot;
    logic       overflow;
    logic       last_result;
  } bcr_res_t;

endpackage

>>> sv/bcr_ram.sv
`timescale 1ns / 1ps
// bcr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bcr_msb.sv
`timescale 1ns / 1ps
// bcr_msb: index of the highest set bit of a 64-bit word, by halving.
// No dependencies.
module bcr_msb (
  input  logic [63:0] word_i,
  output logic [5:0]  idx_o
);

  always_comb begin
    logic [63:0] v;
    v     = word_i;
    idx_o = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((v >> (1 << k)) != 64'd0) begin
        idx_o[k] = 1'b1;
        v        = v >> (1 << k);
      end
    end
  end

endmodule

>>> sv/bcr_seq.sv
`timescale 1ns / 1ps
// bcr_seq: load, pad, scan, owner lookup, XOR, emit and owner clear sequencer.
// Depends on bcr_pkg and bcr_msb; drives the column store and pivot owner RAMs.
module bcr_seq
  import bcr_pkg::*;
#(
  parameter int COL_CAP = 64,
  parameter int ROWS    = 256,
  localparam int WORDS = (ROWS + 63) / 64,
  localparam int SAW   = $clog2(COL_CAP * WORDS),
  localparam int OAW   = $clog2(ROWS),
  localparam int IW    = $clog2(COL_CAP)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bcr_req_t        req_i,
  output logic            result_valid_o,
  output bcr_res_t        result_o,
  output logic            st_we_o,
  output logic [SAW-1:0]  st_waddr_o,
  output logic [63:0]     st_wdata_o,
  output logic [SAW-1:0]  st_raddr_o,
  input  logic [63:0]     st_rdata_i,
  output logic            ow_we_o,
  output logic [OAW-1:0]  ow_waddr_o,
  output logic [IW:0]     ow_wdata_o,
  output logic [OAW-1:0]  ow_raddr_o,
  input  logic [IW:0]     ow_rdata_i
);

  localparam int WAW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCW  = $clog2(WORDS + 1);
  localparam int RW   = WAW + 6;
  localparam int CW   = $clog2(COL_CAP + 1);
  localparam int TAIL = ROWS % 64;
  localparam logic [63:0] TMASK = (TAIL == 0) ? {64{1'b1}} : ((64'd1 << TAIL) - 64'd1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PAD     = 4'd2;
  localparam logic [3:0] S_START   = 4'd3;
  localparam logic [3:0] S_SCAN_RD = 4'd4;
  localparam logic [3:0] S_SCAN_CK = 4'd5;
  localparam logic [3:0] S_OWN_RD  = 4'd6;
  localparam logic [3:0] S_OWN_CK  = 4'd7;
  localparam logic [3:0] S_X_RDO   = 4'd8;
  localparam logic [3:0] S_X_RDI   = 4'd9;
  localparam logic [3:0] S_X_WR    = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  logic [3:0]     state_q, state_d;
  logic [OAW-1:0] clr_q, clr_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic [CW-1:0]  col_q, col_d;
  logic           ovf_q, ovf_d;
  logic           eom_q, eom_d;
  logic [CW-1:0]  i_q, i_d;
  logic [IW-1:0]  o_q, o_d;
  logic [WAW-1:0] w_q, w_d;
  logic [RW-1:0]  p_q, p_d;
  logic           has_q, has_d;
  logic [63:0]    tmp_q, tmp_d;
  logic           rv_q, rv_d;
  bcr_res_t       res_q, res_d;

  logic [5:0]     msb;
  logic           accept;
  logic [IW-1:0]  i_idx;
  logic [RW+7:0]  p_ext;

  bcr_msb u_msb (
    .word_i (st_rdata_i),
    .idx_o  (msb)
  );

  function automatic logic [SAW-1:0] caddr(input logic [CW-1:0] c, input logic [WCW-1:0] w);
    caddr = SAW'(32'(c) * WORDS + 32'(w));
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign i_idx  = i_q[IW-1:0];
  assign p_ext  = {8'd0, p_q};

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wc_d       = wc_q;
    col_d      = col_q;
    ovf_d      = ovf_q;
    eom_d      = eom_q;
    i_d        = i_q;
    o_d        = o_q;
    w_d        = w_q;
    p_d        = p_q;
    has_d      = has_q;
    tmp_d      = tmp_q;
    rv_d       = 1'b0;
    res_d      = res_q;
    st_we_o    = 1'b0;
    st_waddr_o = caddr(i_q, WCW'(w_q));
    st_wdata_o = '0;
    st_raddr_o = caddr(i_q, WCW'(w_q));
    ow_we_o    = 1'b0;
    ow_waddr_o = p_q[OAW-1:0];
    ow_wdata_o = {1'b1, i_idx};
    ow_raddr_o = p_q[OAW-1:0];
    case (state_q)
      S_CLR: begin
        ow_we_o    = 1'b1;
        ow_waddr_o = clr_q;
        ow_wdata_o = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == OAW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          eom_d = req_i.end_of_matrix;
          if (col_q < CW'(COL_CAP)) begin
            if (wc_q < WCW'(WORDS)) begin
              st_we_o    = 1'b1;
              st_waddr_o = caddr(col_q, wc_q);
              st_wdata_o = (wc_q == WCW'(WORDS - 1)) ? (req_i.column_word & TMASK)
                                                      : req_i.column_word;
              wc_d       = wc_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            if (req_i.end_of_column || req_i.end_of_matrix) begin
              if (wc_q < WCW'(WORDS - 1)) begin
                state_d = S_PAD;
              end else begin
                col_d = col_q + 1'b1;
                wc_d  = '0;
                if (req_i.end_of_matrix) begin
                  state_d = S_START;
                end
              end
            end
          end else begin
            ovf_d = 1'b1;
            wc_d  = '0;
            if (req_i.end_of_matrix) begin
              state_d = S_START;
            end
          end
          i_d = '0;
        end
      end
      S_PAD: begin
        st_we_o    = 1'b1;
        st_waddr_o = caddr(col_q, wc_q);
        wc_d       = wc_q + 1'b1;
        if (wc_q == WCW'(WORDS - 1)) begin
          wc_d  = '0;
          col_d = col_q + 1'b1;
          state_d = eom_q ? S_START : S_IDLE;
        end
      end
      S_START: begin
        w_d = WAW'(WORDS - 1);
        if (i_q == col_q) begin
          col_d   = '0;
          wc_d    = '0;
          ovf_d   = 1'b0;
          clr_d   = '0;
          state_d = S_CLR;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (st_rdata_i != 64'd0) begin
          p_d     = {w_q, msb};
          has_d   = 1'b1;
          state_d = S_OWN_RD;
        end else if (w_q == '0) begin
          p_d     = '0;
          has_d   = 1'b0;
          state_d = S_EMIT;
        end else begin
          w_d     = w_q - 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_OWN_RD: begin
        state_d = S_OWN_CK;
      end
      S_OWN_CK: begin
        if (ow_rdata_i[IW] && (ow_rdata_i[IW-1:0] != i_idx)) begin
          o_d     = ow_rdata_i[IW-1:0];
          w_d     = '0;
          state_d = S_X_RDO;
        end else begin
          ow_we_o = !ow_rdata_i[IW];
          state_d = S_EMIT;
        end
      end
      S_X_RDO: begin
        st_raddr_o = caddr(CW'(o_q), WCW'(w_q));
        state_d    = S_X_RDI;
      end
      S_X_RDI: begin
        tmp_d   = st_rdata_i;
        state_d = S_X_WR;
      end
      S_X_WR: begin
        st_we_o    = 1'b1;
        st_wdata_o = st_rdata_i ^ tmp_q;
        if (w_q == WAW'(WORDS - 1)) begin
          state_d = S_SCAN_RD;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = S_X_RDO;
        end
      end
      S_EMIT: begin
        rv_d                = 1'b1;
        res_d.column_number = 6'(i_idx);
        res_d.pivot_row     = p_ext[7:0];
        res_d.has_pivot     = has_q;
        res_d.overflow      = ovf_q;
        res_d.last_result   = (i_q + 1'b1 == col_q);
        i_d                 = i_q + 1'b1;
        state_d             = S_START;
      end
      default: begin
        state_d = S_CLR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      wc_q    <= '0;
      col_q   <= '0;
      ovf_q   <= 1'b0;
      eom_q   <= 1'b0;
      i_q     <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wc_q    <= wc_d;
      col_q   <= col_d;
      ovf_q   <= ovf_d;
      eom_q   <= eom_d;
      i_q     <= i_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q   <= o_d;
    w_q   <= w_d;
    p_q   <= p_d;
    has_q <= has_d;
    tmp_q <= tmp_d;
    res_q <= res_d;
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (i_q < col_q))
    else $error("emit past loaded columns");

  a_owner_earlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_X_RDO) |-> (CW'(o_q) < i_q))
    else $error("reducing by a later column");

  a_last_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |-> busy)
    else $error("idle before owner clear");

endmodule

>>> sv/boundary_column_reduction_gf2_top.sv
`timescale 1ns / 1ps
// Top: GF(2) boundary column reducer. Load words are taken while the block is idle; a short
// column pads its missing words with zeros. Reduction per column: start and emit, a scan
// of the words from the top, owner lookups and XORs of owner words, all through one store
// port; results stream one strobe per column. Then an owner clear pass over all ROWS
// entries runs, also after reset. Async active-low reset; results cannot be stalled.
module boundary_column_reduction_gf2_top
  import bcr_pkg::*;
#(
  parameter int COL_CAP = 64,
  parameter int ROWS    = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  bcr_req_t req_i,
  output logic     result_valid_o,
  output bcr_res_t result_o
);

  localparam int WORDS = (ROWS + 63) / 64;
  localparam int SAW   = $clog2(COL_CAP * WORDS);
  localparam int OAW   = $clog2(ROWS);
  localparam int IW    = $clog2(COL_CAP);

  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [63:0]    st_wdata, st_rdata;
  logic           ow_we;
  logic [OAW-1:0] ow_waddr, ow_raddr;
  logic [IW:0]    ow_wdata, ow_rdata;

  bcr_seq #(
    .COL_CAP (COL_CAP),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .st_we_o        (st_we),
    .st_waddr_o     (st_waddr),
    .st_wdata_o     (st_wdata),
    .st_raddr_o     (st_raddr),
    .st_rdata_i     (st_rdata),
    .ow_we_o        (ow_we),
    .ow_waddr_o     (ow_waddr),
    .ow_wdata_o     (ow_wdata),
    .ow_raddr_o     (ow_raddr),
    .ow_rdata_i     (ow_rdata)
  );

  bcr_ram #(
    .WIDTH (64),
    .DEPTH (COL_CAP * WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  bcr_ram #(
    .WIDTH (IW + 1),
    .DEPTH (ROWS)
  ) u_owner (
    .clk_i   (clk_i),
    .we_i    (ow_we),
    .waddr_i (ow_waddr),
    .wdata_i (ow_wdata),
    .raddr_i (ow_raddr),
    .rdata_o (ow_rdata)
  );

endmodule

>>> verif/bcr_checker.sv
`timescale 1ns / 1ps
// bcr_checker: predicts GF(2) column reduction results from accepted requests
// and compares them with the result strobes. Depends on bcr_pkg.
module bcr_checker
  import bcr_pkg::*;
#(
  parameter int COL_CAP = 64,
  parameter int ROWS    = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  bcr_req_t req_i,
  input  logic     result_valid_o,
  input  bcr_res_t result_o,
  output int       fail_count,
  output int       pending_count,
  output int       result_count
);

  localparam int WORDS = (ROWS + 63) / 64;

  logic [ROWS-1:0] cols [COL_CAP];
  logic [5:0]      owner_of [ROWS];
  logic [ROWS-1:0] owned;
  int              word_idx;
  int              col_idx;
  logic            ovf;
  bcr_res_t        pivots_q[$];

  assign pending_count = pivots_q.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int top_row(input logic [ROWS-1:0] v);
    for (int r = ROWS - 1; r >= 0; r--) if (v[r]) return r;
    return -1;
  endfunction

  task automatic reduce_matrix();
    bcr_res_t r;
    int p;
    for (int i = 0; i < col_idx; i++) begin
      p = top_row(cols[i]);
      while (p >= 0 && owned[p] && owner_of[p] != i) begin
        cols[i] ^= cols[owner_of[p]];
        p = top_row(cols[i]);
      end
      if (p >= 0 && !owned[p]) begin
        owned[p] = 1'b1;
        owner_of[p] = i;
      end
      r.column_number = i[5:0];
      r.pivot_row     = p >= 0 ? p[7:0] : 8'd0;
      r.has_pivot     = p >= 0;
      r.overflow      = ovf;
      r.last_result   = (i + 1 == col_idx);
      pivots_q = {pivots_q, r};
    end
    owned = '0;
    word_idx = 0;
    col_idx = 0;
    ovf = 1'b0;
  endtask

  task automatic absorb_request(input bcr_req_t q);
    logic eoc;
    eoc = q.end_of_column | q.end_of_matrix;
    if (col_idx < COL_CAP) begin
      if (word_idx == 0) cols[col_idx] = '0;
      if (word_idx < WORDS) begin
        for (int k = 0; k < 64; k++)
          if (word_idx * 64 + k < ROWS) cols[col_idx][word_idx*64+k] = q.column_word[k];
        word_idx++;
      end else begin
        ovf = 1'b1;
      end
      if (eoc) begin
        col_idx++;
        word_idx = 0;
      end
    end else begin
      ovf = 1'b1;
      word_idx = 0;
    end
    if (q.end_of_matrix) reduce_matrix();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bcr_res_t e;
    if (!rst_ni) begin
      owned <= '0;
      word_idx <= 0;
      col_idx <= 0;
      ovf <= 1'b0;
      fail_count <= 0;
      result_count <= 0;
      pivots_q.delete();
    end else begin
      if (result_valid_o) begin
        result_count++;
        if (pivots_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = pivots_q.pop_front();
          if (result_o.column_number !== e.column_number)
            report_mismatch($sformatf("column_number %0d exp %0d",
                            result_o.column_number, e.column_number));
          if (result_o.pivot_row !== e.pivot_row)
            report_mismatch($sformatf("col %0d pivot_row %0d exp %0d",
                            e.column_number, result_o.pivot_row, e.pivot_row));
          if (result_o.has_pivot !== e.has_pivot)
            report_mismatch($sformatf("col %0d has_pivot %b exp %b",
                            e.column_number, result_o.has_pivot, e.has_pivot));
          if (result_o.overflow !== e.overflow)
            report_mismatch($sformatf("col %0d overflow %b exp %b",
                            e.column_number, result_o.overflow, e.overflow));
          if (result_o.last_result !== e.last_result)
            report_mismatch($sformatf("col %0d last_result %b exp %b",
                            e.column_number, result_o.last_result, e.last_result));
        end
      end
      if (start && !busy) absorb_request(req_i);
    end
  end

endmodule

>>> verif/tb_boundary_column_reduction_gf2_top.sv
`timescale 1ns / 1ps
// Testbench top: drives matrices of boundary columns into the GF(2) reducer and
// gives the verdict. Depends on bcr_pkg, bcr_checker and the block's top.
module tb_boundary_column_reduction_gf2_top;
  import bcr_pkg::*;

  localparam int  MAX_COLS  = 64;
  localparam int  NROWS     = 256;
  localparam longint LIMIT  = 3_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bcr_req_t req_i = '0;
  logic     result_valid_o;
  bcr_res_t result_o;
  int       fail_count, pending_count, result_count;
  int       idle_pct;
  int       req_count;
  int       matrix_count;

  always #4 clk_i = ~clk_i;

  boundary_column_reduction_gf2_top #(.COL_CAP(MAX_COLS), .ROWS(NROWS)) dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .result_valid_o, .result_o);

  bcr_checker #(.COL_CAP(MAX_COLS), .ROWS(NROWS)) u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .result_valid_o, .result_o,
    .fail_count, .pending_count, .result_count);

  function automatic logic [63:0] rand_word(input int kind);
    case (kind)
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'd1 << $urandom_range(63);
      3: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(input logic [63:0] w, input logic eoc, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{column_word: w, end_of_column: eoc, end_of_matrix: eom};
    do @(posedge clk_i); while (busy);
    req_count++;
  endtask

  // one matrix: ncols columns, each of nw words (0 means random 1..5)
  task automatic send_matrix(input int ncols, input int nw, input int kind);
    int words;
    for (int c = 0; c < ncols; c++) begin
      words = nw != 0 ? nw : $urandom_range(1, 5);
      for (int w = 0; w < words; w++)
        send(rand_word(kind < 0 ? $urandom_range(4) : kind), w == words - 1,
             (w == words - 1) && (c == ncols - 1));
    end
    matrix_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  initial begin
    longint cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > LIMIT) begin
        $display("timeout after %0d cycles", cyc);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    req_count = 0;
    matrix_count = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    send(64'd0, 1'b0, 1'b1);
    send_matrix(1, 4, 1);
    send_matrix(3, 4, 1);
    send_matrix(4, 1, 2);
    send(64'd1, 1'b0, 1'b0);
    send(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    drain();
    // too many words in one column
    send_matrix(1, 6, 4);
    drain();
    // too many columns
    send_matrix(MAX_COLS + 2, 1, 3);
    drain();
    send_matrix(MAX_COLS, 1, 4);
    drain();
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 0 ? 0 : ph == 1 ? 75 : ph == 2 ? 19 : 0;
      repeat (3) begin
        if ($urandom_range(9) == 0) send($urandom_range(1) ? 64'd0 : rand_word(4),
                                         1'b1, 1'b0);
        send_matrix($urandom_range(1, 8), $urandom_range(2) == 0 ? 0 : 1, -1);
        if ($urandom_range(3) == 0) drain();
      end
      drain();
    end
    $display("Ran %0d requests in %0d matrices, %0d results checked,", req_count,
             matrix_count, result_count);
    $display("including padded, overlong and over-capacity columns.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bcr_pkg.sv
sv/bcr_ram.sv
sv/bcr_msb.sv
sv/bcr_seq.sv
sv/boundary_column_reduction_gf2_top.sv
verif/bcr_checker.sv
verif/tb_boundary_column_reduction_gf2_top.sv
